>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

>>> rtl/core/bsft_pkg.sv
// Shared types and constants of the byte-stuffed frame transmitter.
// No dependencies.
package bsft_pkg;

    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLAG    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS = 4'd3;

    localparam logic [BYTE_W-1:0] FLAG_RST    = 8'd126;
    localparam logic [BYTE_W-1:0] ESCAPE_RST  = 8'd125;
    localparam logic [BYTE_W-1:0] MASK_RST    = 8'd32;
    localparam logic [BYTE_W-1:0] ADDRESS_RST = 8'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_value;
        logic [BYTE_W-1:0] escape_value;
        logic [BYTE_W-1:0] stuff_mask;
        logic [BYTE_W-1:0] address_value;
    } cfg_t;

    // one classified item as queued between front and back
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] control;
        logic              first;
        logic              last;
        logic [BYTE_W-1:0] bcc;    // running payload XOR including this byte
    } cmd_t;

    typedef struct packed {
        logic push;
        logic full;
    } q_wr_t;

    typedef struct packed {
        logic pop;
        logic valid;
    } q_rd_t;

endpackage

>>> rtl/core/byte_stuffed_frame_transmitter.sv
// Top level of the byte-stuffed frame transmitter: configuration registers,
// front end, command queue and back end. Depends on bsft_pkg and the bsft_* modules.
//
// Turns payload bytes marked first/last into a byte-stuffed frame, one line
// byte per output transfer. A first byte opens the frame with the flag, then
// the stuffed address, control byte and header check (address XOR control).
// Each payload byte is stuffed: a byte equal to the flag or escape value goes
// out as escape followed by the byte XOR stuff_mask. A last byte appends the
// stuffed running payload XOR and the plain closing flag (frame_end=1).
// run_last marks the final line byte caused by an input transfer. Throughput
// is one line byte per clock while out_ready is high and the queue is not empty;
// an input item produces 1 or 2 line bytes for a plain payload byte, up to 12
// for a one-byte frame, and holds the back end until the last one is loaded.
// Inputs are taken every cycle while the 4-entry command queue has room, so
// bursts are absorbed while the line drains; the first line byte of an item
// goes out through the queue and the output register when the back end is free.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at once;
// indexes 0..3 are flag, escape, stuff mask and address, others are ignored.
module byte_stuffed_frame_transmitter import bsft_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    // input channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    payload_byte,
    input  logic                 frame_first,
    input  logic                 frame_last,
    input  logic [BYTE_W-1:0]    control_byte,
    // output channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_W-1:0]    line_byte,
    output logic                 run_last,
    output logic                 frame_end
);

    cfg_t  cfg_reg;
    cmd_t  push_cmd;
    cmd_t  head_cmd;
    logic  push;
    logic  pop;
    q_wr_t wr_stat;
    q_rd_t rd_stat;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_value    <= FLAG_RST;
            cfg_reg.escape_value  <= ESCAPE_RST;
            cfg_reg.stuff_mask    <= MASK_RST;
            cfg_reg.address_value <= ADDRESS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FLAG:    cfg_reg.flag_value    <= cfg_data;
                REG_ESCAPE:  cfg_reg.escape_value  <= cfg_data;
                REG_MASK:    cfg_reg.stuff_mask    <= cfg_data;
                REG_ADDRESS: cfg_reg.address_value <= cfg_data;
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front: input transfer, running XOR, command build
    bsft_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .payload_byte (payload_byte),
        .frame_first  (frame_first),
        .frame_last   (frame_last),
        .control_byte (control_byte),
        .q_full       (wr_stat.full),
        .q_push       (push),
        .q_cmd        (push_cmd)
    );

    // decouples input acceptance from line output
    bsft_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_cmd  (push_cmd),
        .wr_stat (wr_stat),
        .pop     (pop),
        .rd_stat (rd_stat),
        .rd_cmd  (head_cmd)
    );

    // back: frame sequencing, stuffing, output register
    bsft_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_stat    (rd_stat),
        .q_cmd     (head_cmd),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .line_byte (line_byte),
        .run_last  (run_last),
        .frame_end (frame_end)
    );

endmodule

>>> rtl/core/bsft_front.sv
// Front end: accepts input transfers, keeps the running payload XOR and
// builds queue commands. Depends on bsft_pkg.
module bsft_front import bsft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] payload_byte,
    input  logic              frame_first,
    input  logic              frame_last,
    input  logic [BYTE_W-1:0] control_byte,
    input  logic              q_full,
    output logic              q_push,
    output cmd_t              q_cmd
);

    logic [BYTE_W-1:0] xor_reg;
    logic [BYTE_W-1:0] xor_next;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    // a first byte restarts the check
    assign xor_next = (frame_first ? '0 : xor_reg) ^ payload_byte;

    always_comb
    begin
        q_cmd.data    = payload_byte;
        q_cmd.control = control_byte;
        q_cmd.first   = frame_first;
        q_cmd.last    = frame_last;
        q_cmd.bcc     = xor_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_reg <= '0;
        end
        else if (q_push)
        begin
            xor_reg <= xor_next;
        end
    end

endmodule

>>> rtl/core/bsft_queue.sv
// Small command queue between front and back.
// Depends on bsft_pkg.
module bsft_queue import bsft_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  cmd_t  wr_cmd,
    output q_wr_t wr_stat,
    input  logic  pop,
    output q_rd_t rd_stat,
    output cmd_t  rd_cmd
);

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic                do_push;
    logic                do_pop;

    assign wr_stat.full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign wr_stat.push  = do_push;
    assign rd_stat.valid = (count_reg != '0);
    assign rd_stat.pop   = do_pop;
    assign rd_cmd        = mem_reg[rd_ptr_reg];

    assign do_push = push && !wr_stat.full;
    assign do_pop  = pop && rd_stat.valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/bsft_back.sv
// Back end: walks each queued command through header (first), payload, check and
// closing flag (last), stuffing, into the output register. Depends on bsft_pkg.
module bsft_back import bsft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  q_rd_t             q_stat,
    input  cmd_t              q_cmd,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] line_byte,
    output logic              run_last,
    output logic              frame_end
);

    localparam logic [2:0] S_START = 3'd0;
    localparam logic [2:0] S_OPEN  = 3'd1;
    localparam logic [2:0] S_ADDR  = 3'd2;
    localparam logic [2:0] S_CTRL  = 3'd3;
    localparam logic [2:0] S_HCS   = 3'd4;
    localparam logic [2:0] S_DATA  = 3'd5;
    localparam logic [2:0] S_BCC   = 3'd6;
    localparam logic [2:0] S_CLOSE = 3'd7;

    logic [2:0]        step_reg, step_next, step_eff, step_after;
    logic              esc_reg, esc_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] line_byte_reg, line_byte_next;
    logic              run_last_reg, run_last_next;
    logic              frame_end_reg, frame_end_next;
    logic [BYTE_W-1:0] cur_val;
    logic              stuffed;
    logic              is_close;
    logic              needs_esc;
    logic              step_done;
    logic              item_done;
    logic              load;

    assign step_eff = (step_reg == S_START) ? (q_cmd.first ? S_OPEN : S_DATA) : step_reg;

    always_comb
    begin
        cur_val  = q_cmd.data;
        stuffed  = 1'b1;
        is_close = 1'b0;
        case (step_eff)
            S_OPEN:
            begin
                cur_val = cfg.flag_value;
                stuffed = 1'b0;
            end
            S_ADDR:  cur_val = cfg.address_value;
            S_CTRL:  cur_val = q_cmd.control;
            S_HCS:   cur_val = cfg.address_value ^ q_cmd.control;
            S_DATA:  cur_val = q_cmd.data;
            S_BCC:   cur_val = q_cmd.bcc;
            S_CLOSE:
            begin
                cur_val  = cfg.flag_value;
                stuffed  = 1'b0;
                is_close = 1'b1;
            end
            default: cur_val = q_cmd.data;
        endcase
    end

    always_comb
    begin
        case (step_eff)
            S_OPEN:  step_after = S_ADDR;
            S_ADDR:  step_after = S_CTRL;
            S_CTRL:  step_after = S_HCS;
            S_HCS:   step_after = S_DATA;
            S_DATA:  step_after = q_cmd.last ? S_BCC : S_START;
            S_BCC:   step_after = S_CLOSE;
            S_CLOSE: step_after = S_START;
            default: step_after = S_START;
        endcase
    end

    assign needs_esc = stuffed && ((cur_val == cfg.flag_value) ||
                                   (cur_val == cfg.escape_value));
    // escape byte first, transformed byte on the next output load
    assign step_done = !needs_esc || esc_reg;
    assign item_done = step_done && (step_after == S_START);
    assign load      = q_stat.valid && (!out_valid_reg || out_ready);
    assign q_pop     = load && item_done;

    always_comb
    begin
        step_next      = step_reg;
        esc_next       = esc_reg;
        out_valid_next = out_valid_reg;
        line_byte_next = line_byte_reg;
        run_last_next  = run_last_reg;
        frame_end_next = frame_end_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            run_last_next  = item_done;
            frame_end_next = is_close;
            if (needs_esc && !esc_reg)
            begin
                line_byte_next = cfg.escape_value;
                esc_next       = 1'b1;
            end
            else if (esc_reg)
            begin
                line_byte_next = cur_val ^ cfg.stuff_mask;
                esc_next       = 1'b0;
            end
            else
            begin
                line_byte_next = cur_val;
            end
            if (step_done)
            begin
                step_next = step_after;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_START;
            esc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            esc_reg       <= esc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line_byte_reg <= line_byte_next;
        run_last_reg  <= run_last_next;
        frame_end_reg <= frame_end_next;
    end

    assign out_valid = out_valid_reg;
    assign line_byte = line_byte_reg;
    assign run_last  = run_last_reg;
    assign frame_end = frame_end_reg;

endmodule

>>> rtl/core/bsft_checker.sv
// Port-level checks for the byte-stuffed frame transmitter, bound to the top.
// Depends on bsft_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bsft_checker import bsft_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [BYTE_W-1:0]    line_byte,
    input logic                 run_last,
    input logic                 frame_end
);

    // closing flag always ends the run of its input
    `CHK_IMPLY(a_close_is_last, clk, rst_n, out_valid && frame_end, run_last, "closing flag without run_last")

    // bytes of one item go out with no gaps
    `CHK_NEXT(a_run_no_gap, clk, rst_n, out_valid && out_ready && !run_last, out_valid, "gap inside a run")

    // stalled output holds
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(line_byte) && $stable(run_last) && $stable(frame_end), "stalled output changed")

endmodule

bind byte_stuffed_frame_transmitter bsft_checker u_bsft_checker (.*);
